[rtl/npfp_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// npfp_pkg
// Shared constants and field layout of the position/velocity/time fix frame.
// ----------------------------------------------------------------------------
package npfp_pkg;

    // payload buffer sizing
    localparam int PAYLOAD_CAPACITY = 128;
    localparam int ADDR_W           = $clog2(PAYLOAD_CAPACITY);
    localparam int POS_W            = 16;

    // result word layout
    localparam int FIELD_W = 5;
    localparam int VALUE_W = 33;
    localparam int ACC_W   = 32;

    // frame constants
    localparam logic [7:0]         SYNC_CHAR_1 = 8'hB5;
    localparam logic [7:0]         SYNC_CHAR_2 = 8'h62;
    localparam logic [7:0]         CLASS_NAV   = 8'h01;
    localparam logic [7:0]         ID_PVT      = 8'h07;
    localparam logic [POS_W-1:0]   FIX_LEN     = 16'd92;
    localparam logic [7:0]         FIX_TYPE_3D = 8'd3;

    // field indexes that need special handling
    localparam logic [FIELD_W-1:0] FLD_FIXTYPE = 5'd1;
    localparam logic [FIELD_W-1:0] FLD_FLAGS   = 5'd2;
    localparam logic [FIELD_W-1:0] FLD_VALID3D = 5'd16;

    // payload offset of each field
    function automatic logic [ADDR_W-1:0] fld_start(input logic [FIELD_W-1:0] f);
        logic [ADDR_W-1:0] s;
        unique case (f)
            5'd0:    s = ADDR_W'(0);
            5'd1:    s = ADDR_W'(20);
            5'd2:    s = ADDR_W'(21);
            5'd3:    s = ADDR_W'(23);
            5'd4:    s = ADDR_W'(24);
            5'd5:    s = ADDR_W'(28);
            5'd6:    s = ADDR_W'(32);
            5'd7:    s = ADDR_W'(36);
            5'd8:    s = ADDR_W'(40);
            5'd9:    s = ADDR_W'(44);
            5'd10:   s = ADDR_W'(48);
            5'd11:   s = ADDR_W'(52);
            5'd12:   s = ADDR_W'(56);
            5'd13:   s = ADDR_W'(60);
            5'd14:   s = ADDR_W'(68);
            5'd15:   s = ADDR_W'(76);
            default: s = ADDR_W'(0);
        endcase
        return s;
    endfunction

    // number of payload bytes in each field, valid3d reads none
    function automatic logic [2:0] fld_bytes(input logic [FIELD_W-1:0] f);
        logic [2:0] n;
        unique case (f)
            5'd1, 5'd2, 5'd3: n = 3'd1;
            5'd15:            n = 3'd2;
            5'd16:            n = 3'd0;
            default:          n = 3'd4;
        endcase
        return n;
    endfunction

    // fields that are sign-extended from 32 bits
    function automatic logic fld_signed(input logic [FIELD_W-1:0] f);
        logic sg;
        unique case (f)
            5'd4, 5'd5, 5'd6, 5'd7, 5'd10, 5'd11, 5'd12: sg = 1'b1;
            default:                                     sg = 1'b0;
        endcase
        return sg;
    endfunction

endpackage

[rtl/nav_pvt_frame_parser_unit.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nav_pvt_frame_parser_unit
// Frame parser for a binary receiver stream with fix decoding.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (i_in_valid / o_in_ready / i_data_byte) takes one stream
//   byte per word. While parsing, a byte is taken every cycle.
//   The parser hunts for the two sync bytes, takes class, id and length,
//   writes the payload into a 128 x 8 buffer RAM and keeps the Fletcher sum.
//   After the last checksum byte of a good fix frame, o_in_ready drops and
//   17 result words (field index, value, last flag) go out on the output
//   channel (o_out_valid / i_out_ready), in field order.
//   Each field's payload bytes are read one at a time from the buffer
//   RAM (registered read, then capture) before the word is presented.
//   If the receiver stalls, the result word holds and input stays stalled.
//   Reset returns the parser to sync hunting with no result pending; the
//   buffer RAM is not cleared, since only freshly written bytes are read.
// ----------------------------------------------------------------------------
module nav_pvt_frame_parser_unit (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_in_valid,
    output logic                                 o_in_ready,
    input  logic [7:0]                           i_data_byte,
    output logic                                 o_out_valid,
    input  logic                                 i_out_ready,
    output logic [npfp_pkg::FIELD_W-1:0]         o_field_index,
    output logic signed [npfp_pkg::VALUE_W-1:0]  o_field_value,
    output logic                                 o_last_field
);

    typedef enum logic [3:0] {
        PH_SYNC1, PH_SYNC2, PH_CLASS, PH_ID, PH_LEN_LO, PH_LEN_HI,
        PH_PAYLOAD, PH_CK_A, PH_CK_B
    } t_phase;

    typedef enum logic [1:0] {
        ST_PARSE, ST_READ, ST_CAPT, ST_OUT
    } t_state;

    t_state                           r_state;
    t_phase                           r_phase;
    logic [7:0]                       r_class;
    logic [7:0]                       r_id;
    logic [npfp_pkg::POS_W-1:0]       r_len;
    logic [npfp_pkg::POS_W-1:0]       r_pos;
    logic [7:0]                       r_sum_a;
    logic [7:0]                       r_sum_b;
    logic [npfp_pkg::FIELD_W-1:0]     r_field;
    logic [2:0]                       r_byte;
    logic [npfp_pkg::ACC_W-1:0]       r_acc;
    logic [7:0]                       r_fix;
    logic [7:0]                       r_flg;

    logic [7:0]                       r_mem [npfp_pkg::PAYLOAD_CAPACITY];
    logic [7:0]                       r_rd_data;

    logic                             w_in_acc;
    logic [7:0]                       n_sum_a;
    logic [7:0]                       n_sum_b;
    logic [npfp_pkg::POS_W-1:0]       n_pos;
    logic [npfp_pkg::POS_W-1:0]       w_len_full;
    logic                             w_good;
    logic                             w_wr_en;
    logic [npfp_pkg::ADDR_W-1:0]      w_rd_addr;
    logic [2:0]                       w_nbytes;
    logic                             w_valid3d;
    logic [npfp_pkg::VALUE_W-1:0]     w_value;

    assign o_in_ready = (r_state == ST_PARSE);
    assign w_in_acc   = i_in_valid && o_in_ready;

    // fletcher sum, restarted on the class byte
    always_comb begin
        n_sum_a = (r_phase == PH_CLASS) ? i_data_byte : r_sum_a + i_data_byte;
        n_sum_b = (r_phase == PH_CLASS) ? i_data_byte : r_sum_b + n_sum_a;
    end

    // frame bookkeeping
    assign n_pos      = r_pos + 16'd1;
    assign w_len_full = {i_data_byte, r_len[7:0]};
    assign w_good     = (i_data_byte == r_sum_b) && (r_class == npfp_pkg::CLASS_NAV)
                        && (r_id == npfp_pkg::ID_PVT) && (r_len == npfp_pkg::FIX_LEN);
    assign w_wr_en    = w_in_acc && (r_phase == PH_PAYLOAD)
                        && (r_pos < npfp_pkg::POS_W'(npfp_pkg::PAYLOAD_CAPACITY));

    // field decode
    assign w_rd_addr = npfp_pkg::fld_start(r_field) + npfp_pkg::ADDR_W'(r_byte);
    assign w_nbytes  = npfp_pkg::fld_bytes(r_field);
    assign w_valid3d = r_flg[0] && (r_fix >= npfp_pkg::FIX_TYPE_3D);
    assign w_value   = {npfp_pkg::fld_signed(r_field) & r_acc[npfp_pkg::ACC_W-1], r_acc};

    // payload buffer ram, one write and one registered read port
    always_ff @(posedge i_clk) begin
        if (w_wr_en) begin
            r_mem[r_pos[npfp_pkg::ADDR_W-1:0]] <= i_data_byte;
        end
        r_rd_data <= r_mem[w_rd_addr];
    end

    // parser and result sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_PARSE;
            r_phase     <= PH_SYNC1;
            r_class     <= '0;
            r_id        <= '0;
            r_len       <= '0;
            r_pos       <= '0;
            r_sum_a     <= '0;
            r_sum_b     <= '0;
            r_field     <= '0;
            r_byte      <= '0;
            o_out_valid <= 1'b0;
        end else begin
            unique case (r_state)
                ST_PARSE: begin
                    if (w_in_acc) begin
                        unique case (r_phase)
                            PH_SYNC1: begin
                                if (i_data_byte == npfp_pkg::SYNC_CHAR_1) begin
                                    r_phase <= PH_SYNC2;
                                end
                            end
                            PH_SYNC2: begin
                                r_phase <= (i_data_byte == npfp_pkg::SYNC_CHAR_2) ?
                                           PH_CLASS : PH_SYNC1;
                            end
                            PH_CLASS: begin
                                r_class <= i_data_byte;
                                r_sum_a <= n_sum_a;
                                r_sum_b <= n_sum_b;
                                r_phase <= PH_ID;
                            end
                            PH_ID: begin
                                r_id    <= i_data_byte;
                                r_sum_a <= n_sum_a;
                                r_sum_b <= n_sum_b;
                                r_phase <= PH_LEN_LO;
                            end
                            PH_LEN_LO: begin
                                r_len   <= {8'd0, i_data_byte};
                                r_sum_a <= n_sum_a;
                                r_sum_b <= n_sum_b;
                                r_phase <= PH_LEN_HI;
                            end
                            PH_LEN_HI: begin
                                r_len   <= w_len_full;
                                r_sum_a <= n_sum_a;
                                r_sum_b <= n_sum_b;
                                r_pos   <= '0;
                                if (w_len_full >
                                    npfp_pkg::POS_W'(npfp_pkg::PAYLOAD_CAPACITY)) begin
                                    r_phase <= PH_SYNC1;
                                end else if (w_len_full == '0) begin
                                    r_phase <= PH_CK_A;
                                end else begin
                                    r_phase <= PH_PAYLOAD;
                                end
                            end
                            PH_PAYLOAD: begin
                                r_pos   <= n_pos;
                                r_sum_a <= n_sum_a;
                                r_sum_b <= n_sum_b;
                                if (n_pos >= r_len) begin
                                    r_phase <= PH_CK_A;
                                end
                            end
                            PH_CK_A: begin
                                r_phase <= (i_data_byte == r_sum_a) ? PH_CK_B : PH_SYNC1;
                            end
                            PH_CK_B: begin
                                r_phase <= PH_SYNC1;
                                if (w_good) begin
                                    r_state <= ST_READ;
                                    r_field <= '0;
                                    r_byte  <= '0;
                                    r_acc   <= '0;
                                end
                            end
                            default: begin
                                r_phase <= PH_SYNC1;
                            end
                        endcase
                    end
                end
                ST_READ: begin
                    // address goes to the ram here, data is captured next cycle
                    if (r_byte == w_nbytes) begin
                        o_field_index <= r_field;
                        o_field_value <= (r_field == npfp_pkg::FLD_VALID3D) ?
                                         {32'd0, w_valid3d} : w_value;
                        o_last_field  <= (r_field == npfp_pkg::FLD_VALID3D);
                        o_out_valid   <= 1'b1;
                        r_state       <= ST_OUT;
                    end else begin
                        r_state <= ST_CAPT;
                    end
                end
                ST_CAPT: begin
                    r_acc[8*r_byte[1:0] +: 8] <= r_rd_data;
                    if (r_field == npfp_pkg::FLD_FIXTYPE) begin
                        r_fix <= r_rd_data;
                    end
                    if (r_field == npfp_pkg::FLD_FLAGS) begin
                        r_flg <= r_rd_data;
                    end
                    r_byte  <= r_byte + 3'd1;
                    r_state <= ST_READ;
                end
                ST_OUT: begin
                    if (i_out_ready) begin
                        o_out_valid <= 1'b0;
                        if (o_last_field) begin
                            r_state <= ST_PARSE;
                        end else begin
                            r_field <= r_field + 5'd1;
                            r_byte  <= '0;
                            r_acc   <= '0;
                            r_state <= ST_READ;
                        end
                    end
                end
                default: begin
                    r_state <= ST_PARSE;
                end
            endcase
        end
    end

endmodule

[rtl/npfp_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// npfp_checker
// Port-level checks of the frame parser, bound to the parser unit.
// ----------------------------------------------------------------------------
module npfp_checker (
    input logic                                 i_clk,
    input logic                                 i_rst_n,
    input logic                                 o_in_ready,
    input logic                                 o_out_valid,
    input logic                                 i_out_ready,
    input logic [npfp_pkg::FIELD_W-1:0]         o_field_index,
    input logic signed [npfp_pkg::VALUE_W-1:0]  o_field_value,
    input logic                                 o_last_field
);

    // a stalled result word holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_field_index)
        && $stable(o_field_value) && $stable(o_last_field))
        else $error("result word changed while stalled");

    // no byte is taken while a result is pending
    a_no_in_during_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> !o_in_ready)
        else $error("input taken during result burst");

    // the last flag marks only the valid3d field
    a_last_idx: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_last_field == (o_field_index == npfp_pkg::FLD_VALID3D)))
        else $error("last flag on wrong field");

    // valid3d is a single bit
    a_valid3d_bit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_last_field |-> (o_field_value[npfp_pkg::VALUE_W-1:1] == '0))
        else $error("valid3d value out of range");

    // a burst keeps the input stalled until its last word is taken
    a_burst_cont: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_ready && !o_last_field |=> !o_in_ready)
        else $error("input reopened in mid burst");

endmodule

bind nav_pvt_frame_parser_unit npfp_checker u_npfp_checker (.*);
